@@ hw/rtl/fsc_pkg.sv @@
package fsc_pkg;

    localparam int PlaneCount = 6;
    localparam int RegCount   = 8;
    localparam int RegWidth   = 64;
    localparam int IdxWidth   = 3;
    localparam int CoordWidth = 32;
    localparam int RadWidth   = 31;
    localparam int CompWidth  = 33;
    // length squared: three 66-bit squares summed
    localparam int Len2Width  = 68;
    localparam int LenWidth   = 35;
    // distance sum: 65-bit products, three of them plus d<<16, plus r*len (66 bits)
    localparam int DistWidth  = 70;

    localparam logic [RegWidth-1:0] RegReset [RegCount] = '{
        64'd65536, 64'd0, 64'h0001_0000_0000_0000, 64'd0,
        64'd0, 64'd65536, 64'd0, 64'h0001_0000_0000_0000
    };

    // row paired with row 3 and whether it is added
    localparam logic [1:0] PlaneRow [PlaneCount] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
    localparam logic       PlaneAdd [PlaneCount] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

    typedef logic signed [CompWidth-1:0] t_comp;

    typedef struct packed {
        t_comp a;
        t_comp b;
        t_comp c;
        t_comp d;
    } t_plane;

    // one signed Q16.16 matrix element out of the register bank
    function automatic logic signed [CoordWidth-1:0] elem(
        input logic [RegCount*RegWidth-1:0] regs,
        input int unsigned k
    );
        logic [RegWidth-1:0] r;
        r = regs[(k/2)*RegWidth +: RegWidth];
        return (k % 2 == 1) ? r[63:32] : r[31:0];
    endfunction

endpackage

@@ hw/rtl/fsc_stream_if.sv @@
interface fsc_stream_if #(parameter int Width = 1);
    logic             valid;
    logic             ready;
    logic [Width-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/fsc_plane_len.sv @@
// per-plane components and normal length, from configuration only
// square root by one bit per cycle, restarted whenever the matrix changes
module fsc_plane_len (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    input  logic [fsc_pkg::RegCount*fsc_pkg::RegWidth-1:0]      i_regs,
    input  logic                                               i_cfg_we,
    output fsc_pkg::t_plane                                    o_plane [fsc_pkg::PlaneCount],
    output logic [fsc_pkg::LenWidth-1:0]                       o_len [fsc_pkg::PlaneCount],
    output logic                                               o_busy
);
    localparam int BitW = $clog2(fsc_pkg::LenWidth);
    localparam int SqW  = 2*fsc_pkg::CompWidth;

    logic [fsc_pkg::Len2Width-1:0] r_len2 [fsc_pkg::PlaneCount];
    logic [fsc_pkg::LenWidth-1:0]  r_root [fsc_pkg::PlaneCount];
    logic [BitW-1:0]               r_bit;
    logic                          r_busy;
    logic                          r_load;

    // plane components are plain adds or subtracts of register fields
    always_comb begin
        for (int p = 0; p < fsc_pkg::PlaneCount; p++) begin
            fsc_pkg::t_comp cv [4];
            for (int j = 0; j < 4; j++) begin
                fsc_pkg::t_comp base, oth;
                base = fsc_pkg::t_comp'(fsc_pkg::elem(i_regs, 4*j+3));
                oth  = fsc_pkg::t_comp'(fsc_pkg::elem(i_regs, 4*j+int'(fsc_pkg::PlaneRow[p])));
                cv[j] = fsc_pkg::PlaneAdd[p] ? base + oth : base - oth;
            end
            o_plane[p] = '{a: cv[0], b: cv[1], c: cv[2], d: cv[3]};
        end
    end

    // load squared length, then one root bit per cycle from the top
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_load <= 1'b1;
            r_busy <= 1'b1;
        end else if (r_load) begin
            r_load <= 1'b0;
            r_bit  <= BitW'(fsc_pkg::LenWidth-1);
            for (int p = 0; p < fsc_pkg::PlaneCount; p++) begin
                r_len2[p] <= fsc_pkg::Len2Width'($unsigned(SqW'(o_plane[p].a) * SqW'(o_plane[p].a)))
                           + fsc_pkg::Len2Width'($unsigned(SqW'(o_plane[p].b) * SqW'(o_plane[p].b)))
                           + fsc_pkg::Len2Width'($unsigned(SqW'(o_plane[p].c) * SqW'(o_plane[p].c)));
                r_root[p] <= '0;
            end
        end else if (r_busy) begin
            for (int p = 0; p < fsc_pkg::PlaneCount; p++) begin
                logic [fsc_pkg::LenWidth-1:0] cand;
                cand = r_root[p] | (fsc_pkg::LenWidth'(1) << r_bit);
                if ((2*fsc_pkg::LenWidth)'(cand) * (2*fsc_pkg::LenWidth)'(cand)
                        <= (2*fsc_pkg::LenWidth)'(r_len2[p]))
                    r_root[p] <= cand;
            end
            if (r_bit == '0) r_busy <= 1'b0;
            else r_bit <= r_bit - 1'b1;
        end
    end

    assign o_len  = r_root;
    assign o_busy = r_busy;

endmodule

@@ hw/rtl/fsc_cull_pipe.sv @@
// three-stage plane test: products, sums, sign reduce
module fsc_cull_pipe (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fsc_pkg::t_plane               i_plane [fsc_pkg::PlaneCount],
    input  logic [fsc_pkg::LenWidth-1:0]  i_len [fsc_pkg::PlaneCount],
    input  logic                          i_busy,
    fsc_stream_if.sink                    s_in,
    fsc_stream_if.source                  m_out
);
    localparam int PW = 2*fsc_pkg::CompWidth;
    localparam int RW = fsc_pkg::RadWidth + fsc_pkg::LenWidth;

    logic r_v1, r_v2, r_v3;
    logic adv;
    logic signed [PW-1:0] r_px [fsc_pkg::PlaneCount];
    logic signed [PW-1:0] r_py [fsc_pkg::PlaneCount];
    logic signed [PW-1:0] r_pz [fsc_pkg::PlaneCount];
    logic signed [PW-1:0] r_pd [fsc_pkg::PlaneCount];
    logic [RW-1:0]        r_pr [fsc_pkg::PlaneCount];
    logic [fsc_pkg::PlaneCount-1:0] r_neg;
    logic r_vis;

    // whole pipe moves together; output register holds on stall
    assign adv = !r_v3 || m_out.ready;
    assign s_in.ready = adv && !i_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v1 <= s_in.valid && !i_busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // stage 1: products
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int p = 0; p < fsc_pkg::PlaneCount; p++) begin
                r_px[p] <= PW'(i_plane[p].a) * PW'($signed(s_in.data[31:0]));
                r_py[p] <= PW'(i_plane[p].b) * PW'($signed(s_in.data[63:32]));
                r_pz[p] <= PW'(i_plane[p].c) * PW'($signed(s_in.data[95:64]));
                r_pd[p] <= PW'(i_plane[p].d) <<< 16;
                r_pr[p] <= RW'(s_in.data[126:96]) * RW'(i_len[p]);
            end
        end
    end

    // stage 2: full-width sums and sign
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int p = 0; p < fsc_pkg::PlaneCount; p++) begin
                logic signed [fsc_pkg::DistWidth-1:0] s;
                s = fsc_pkg::DistWidth'(r_px[p]) + fsc_pkg::DistWidth'(r_py[p])
                  + fsc_pkg::DistWidth'(r_pz[p]) + fsc_pkg::DistWidth'(r_pd[p])
                  + fsc_pkg::DistWidth'($signed({1'b0, r_pr[p]}));
                r_neg[p] <= s[fsc_pkg::DistWidth-1];
            end
        end
    end

    // stage 3: any rejecting plane culls
    always_ff @(posedge i_clk) begin
        if (adv) r_vis <= ~|r_neg;
    end

    assign m_out.valid = r_v3;
    assign m_out.data  = r_vis;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !m_out.ready |=> r_v3 && $stable(r_vis))
        else $error("result lost under stall");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_busy |-> !s_in.ready)
        else $error("request taken while lengths settle");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_v2 |=> r_v3)
        else $error("item dropped in pipe");

endmodule

@@ hw/rtl/frustum_sphere_cull.sv @@
// Sphere-versus-frustum cull. Each accepted sphere gives one visible bit via the product, sum
// and reduce registers; one request per cycle is taken unless the output stalls or lengths
// settle. Plane normal lengths depend only on the matrix and are computed by a bit-serial
// square root after reset and after every matrix write. Write the matrix only when idle.
module frustum_sphere_cull (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [fsc_pkg::IdxWidth-1:0]      i_cfg_idx,
    input  logic [fsc_pkg::RegWidth-1:0]      i_cfg_data,
    fsc_stream_if.sink                        s_in,
    fsc_stream_if.source                      m_out
);
    logic [fsc_pkg::RegCount*fsc_pkg::RegWidth-1:0] r_regs;
    fsc_pkg::t_plane                 plane [fsc_pkg::PlaneCount];
    logic [fsc_pkg::LenWidth-1:0]    len [fsc_pkg::PlaneCount];
    logic                            busy;

    // matrix register bank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < fsc_pkg::RegCount; i++)
                r_regs[i*fsc_pkg::RegWidth +: fsc_pkg::RegWidth] <= fsc_pkg::RegReset[i];
        end else if (i_cfg_we) begin
            r_regs[i_cfg_idx*fsc_pkg::RegWidth +: fsc_pkg::RegWidth] <= i_cfg_data;
        end
    end

    fsc_plane_len u_len (
        .i_clk, .i_rst_n, .i_regs(r_regs), .i_cfg_we,
        .o_plane(plane), .o_len(len), .o_busy(busy)
    );

    fsc_cull_pipe u_pipe (
        .i_clk, .i_rst_n, .i_plane(plane), .i_len(len), .i_busy(busy),
        .s_in, .m_out
    );

endmodule
